### rtl/rsrg_pkg.sv
// Shared types and constants for the replacement-selection run generator.
package rsrg_pkg;

  localparam int KEY_W          = 32;
  localparam int RUN_W          = 16;
  localparam int FILL_W         = 6;
  localparam int HEAP_DEPTH_DEF = 32;

  localparam logic [FILL_W-1:0] HEAP_FILL_RST = FILL_W'(32);
  localparam logic [RUN_W-1:0]  RUN_MAX       = '1;

  // heap engine operations
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // request to the heap engine
  typedef struct packed {
    logic start;
    logic op;
    logic half;
  } hcmd_t;

endpackage

### rtl/rsrg_heap.sv
// Heap store with push and pop sift engine over one shared memory.
module rsrg_heap #(
  parameter int HEAP_DEPTH = rsrg_pkg::HEAP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rsrg_pkg::hcmd_t                    cmd,
  input  logic [$clog2(HEAP_DEPTH+1)-1:0]    cmd_count,
  input  logic [rsrg_pkg::KEY_W-1:0]         cmd_value,
  output logic                               rsp_done,
  output logic [rsrg_pkg::KEY_W-1:0]         rsp_data
);
  import rsrg_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] H_IDLE   = 3'd0;
  localparam logic [2:0] H_PU_RD  = 3'd1;
  localparam logic [2:0] H_PU_CMP = 3'd2;
  localparam logic [2:0] H_PO_LD  = 3'd3;
  localparam logic [2:0] H_PO_RD  = 3'd4;
  localparam logic [2:0] H_PO_CMP = 3'd5;

  logic [KEY_W-1:0] mem [HEAP_DEPTH];
  logic [KEY_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]    ra, rb, wa;
  logic [KEY_W-1:0] wd;
  logic             we;

  logic [2:0]       st_r, st_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [KEY_W-1:0] x_r, x_nxt;
  logic [KEY_W-1:0] top_r, top_nxt;
  logic             half_r, half_nxt;
  logic             done_r, done_nxt;

  logic [AW-1:0]    par;
  logic [IW-1:0]    l_idx, r_idx;
  logic             l_ok, r_ok, pick_l, pick_r;
  logic [KEY_W-1:0] l_min;

  // map a heap index to a store address for the given half
  function automatic logic [AW-1:0] slot(input logic h, input logic [AW-1:0] idx);
    return h ? AW'(HEAP_DEPTH - 1) - idx : idx;
  endfunction

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  assign par   = (i_r - AW'(1)) >> 1;
  assign l_idx = {1'b0, i_r, 1'b1};
  assign r_idx = l_idx + IW'(1);
  assign l_ok  = l_idx < IW'(n_r);
  assign r_ok  = r_idx < IW'(n_r);

  // pick smallest of hole value and children, left wins ties
  always_comb begin
    pick_l = l_ok && ($signed(rd_a_r) < $signed(x_r));
    l_min  = pick_l ? rd_a_r : x_r;
    pick_r = r_ok && ($signed(rd_b_r) < $signed(l_min));
  end

  // sift sequencer
  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    n_nxt    = n_r;
    x_nxt    = x_r;
    top_nxt  = top_r;
    half_nxt = half_r;
    done_nxt = 1'b0;
    we       = 1'b0;
    wa       = slot(half_r, i_r);
    wd       = x_r;
    ra       = '0;
    rb       = '0;
    unique case (st_r)
      H_IDLE: begin
        if (cmd.start) begin
          half_nxt = cmd.half;
          if (cmd.op == OP_PUSH) begin
            x_nxt = cmd_value;
            if (cmd_count < CW'(HEAP_DEPTH)) begin
              i_nxt  = cmd_count[AW-1:0];
              st_nxt = H_PU_RD;
            end else begin
              done_nxt = 1'b1;
            end
          end else begin
            if (cmd_count == '0) begin
              top_nxt  = '0;
              done_nxt = 1'b1;
            end else begin
              n_nxt  = cmd_count - CW'(1);
              ra     = slot(cmd.half, '0);
              rb     = slot(cmd.half, n_nxt[AW-1:0]);
              st_nxt = H_PO_LD;
            end
          end
        end
      end
      H_PU_RD: begin
        if (i_r == '0) begin
          we       = 1'b1;
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end else begin
          ra     = slot(half_r, par);
          st_nxt = H_PU_CMP;
        end
      end
      H_PU_CMP: begin
        we = 1'b1;
        if ($signed(rd_a_r) > $signed(x_r)) begin
          wd     = rd_a_r;
          i_nxt  = par;
          st_nxt = H_PU_RD;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end
      end
      H_PO_LD: begin
        top_nxt = rd_a_r;
        x_nxt   = rd_b_r;
        i_nxt   = '0;
        st_nxt  = H_PO_RD;
      end
      H_PO_RD: begin
        ra     = l_ok ? slot(half_r, l_idx[AW-1:0]) : '0;
        rb     = r_ok ? slot(half_r, r_idx[AW-1:0]) : '0;
        st_nxt = H_PO_CMP;
      end
      H_PO_CMP: begin
        we = 1'b1;
        if (pick_r) begin
          wd     = rd_b_r;
          i_nxt  = r_idx[AW-1:0];
          st_nxt = H_PO_RD;
        end else if (pick_l) begin
          wd     = rd_a_r;
          i_nxt  = l_idx[AW-1:0];
          st_nxt = H_PO_RD;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end
      end
      default: begin
        st_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    x_r    <= x_nxt;
    top_r  <= top_nxt;
    half_r <= half_nxt;
  end

  assign rsp_done = done_r;
  assign rsp_data = top_r;

endmodule

### rtl/replacement_selection_run_generator_top.sv
// Replacement-selection run generator: control sequencer, result register, heap engine.
//
// Usage: keys enter on the in_ stream (in_tdata = key, in_tlast = final key of the
// stream). Sorted keys leave on the out_ stream with their run number; out_tuser
// flags the last key of a run and out_tlast the last result caused by one request.
// cfg_data sets how many keys the dual heap holds (0 acts as 1, above HEAP_DEPTH
// acts as HEAP_DEPTH); write it only while the block is idle.
// Operation: each request runs alone. A fill request takes one push. A steady
// request takes a pop plus a push; the sift loop through the single-write-port heap
// memory sets its duration, with one read state and one compare state per heap level.
// A final request then drains every held key.
// A one-entry result register sits between the sequencer and out_; while the
// receiver stalls, the next request is still accepted and worked on until it
// needs to place a result. Reset clears all counters, the run number and the
// side select; the heap memory needs no clearing pass.
module replacement_selection_run_generator_top #(
  parameter int HEAP_DEPTH = rsrg_pkg::HEAP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] value
  input  logic                              in_tlast,   // last_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [47:0]                       out_tdata,  // [31:0] out_value, [47:32] run_number
  output logic                              out_tuser,  // run_end
  output logic                              out_tlast,  // last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsrg_pkg::FILL_W-1:0]       cfg_data    // heap_fill
);
  import rsrg_pkg::*;

  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILLW = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PUSHI = 4'd4;
  localparam logic [3:0] S_PUSHW = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DPOPW = 4'd8;
  localparam logic [3:0] S_DEMIT = 4'd9;

  logic [3:0]        st_r, st_nxt;
  logic [CW-1:0]     cur_r, cur_nxt, pend_r, pend_nxt, fill_r, fill_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              side_r, side_nxt;
  logic [FILL_W-1:0] hf_r;
  logic [KEY_W-1:0]  v_r, v_nxt, pop_r, pop_nxt;
  logic              fin_r, fin_nxt, tocur_r, tocur_nxt;

  hcmd_t             cmd_r, cmd_nxt;
  logic [CW-1:0]     ccnt_r, ccnt_nxt;
  logic [KEY_W-1:0]  cval_r, cval_nxt;
  logic              h_done;
  logic [KEY_W-1:0]  h_data;

  logic              ov_r, ov_nxt, ouser_r, ouser_nxt, olast_r, olast_nxt;
  logic [47:0]       odata_r, odata_nxt;
  logic              out_free;

  logic [CW-1:0]     eff;
  logic [CW-1:0]     sw_cur;
  logic              sw_side;

  // hold the fill register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hf_r <= HEAP_FILL_RST;
    end else if (cfg_valid) begin
      hf_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // clamp fill to 1..HEAP_DEPTH
  always_comb begin
    if (hf_r == '0) begin
      eff = CW'(1);
    end else if ({1'b0, hf_r} > (FILL_W + 1)'(HEAP_DEPTH)) begin
      eff = CW'(HEAP_DEPTH);
    end else begin
      eff = CW'(hf_r);
    end
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_free  = !ov_r || out_tready;

  // run sequencer
  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    run_nxt   = run_r;
    side_nxt  = side_r;
    v_nxt     = v_r;
    pop_nxt   = pop_r;
    fin_nxt   = fin_r;
    tocur_nxt = tocur_r;
    cmd_nxt   = '{start: 1'b0, op: cmd_r.op, half: cmd_r.half};
    ccnt_nxt  = ccnt_r;
    cval_nxt  = cval_r;
    ov_nxt    = ov_r && !out_tready;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    olast_nxt = olast_r;
    sw_cur    = cur_r;
    sw_side   = side_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          v_nxt   = in_tdata;
          fin_nxt = in_tlast;
          if (fill_r < eff) begin
            fill_nxt = fill_r + CW'(1);
            cmd_nxt  = '{start: 1'b1, op: OP_PUSH, half: side_r};
            ccnt_nxt = cur_r;
            cval_nxt = in_tdata;
            st_nxt   = S_FILLW;
          end else begin
            st_nxt = S_PRE;
          end
        end
      end
      S_FILLW: begin
        if (h_done) begin
          if (cur_r < CW'(HEAP_DEPTH)) begin
            cur_nxt = cur_r + CW'(1);
          end
          st_nxt = fin_r ? S_DRAIN : S_IDLE;
        end
      end
      S_PRE: begin
        // swap heaps when the current one is empty
        if (cur_r == '0) begin
          sw_cur   = pend_r;
          sw_side  = !side_r;
          cur_nxt  = pend_r;
          pend_nxt = cur_r;
          side_nxt = !side_r;
          if (run_r != RUN_MAX) begin
            run_nxt = run_r + RUN_W'(1);
          end
        end
        cmd_nxt  = '{start: 1'b1, op: OP_POP, half: sw_side};
        ccnt_nxt = sw_cur;
        st_nxt   = S_POPW;
      end
      S_POPW: begin
        if (h_done) begin
          pop_nxt = h_data;
          if (cur_r != '0) begin
            cur_nxt = cur_r - CW'(1);
          end
          st_nxt = S_PUSHI;
        end
      end
      S_PUSHI: begin
        cval_nxt = v_r;
        if ($signed(v_r) > $signed(pop_r)) begin
          tocur_nxt = 1'b1;
          cmd_nxt   = '{start: 1'b1, op: OP_PUSH, half: side_r};
          ccnt_nxt  = cur_r;
        end else begin
          tocur_nxt = 1'b0;
          cmd_nxt   = '{start: 1'b1, op: OP_PUSH, half: !side_r};
          ccnt_nxt  = pend_r;
        end
        st_nxt = S_PUSHW;
      end
      S_PUSHW: begin
        if (h_done) begin
          if (tocur_r && (cur_r < CW'(HEAP_DEPTH))) begin
            cur_nxt = cur_r + CW'(1);
          end else if (!tocur_r && (pend_r < CW'(HEAP_DEPTH))) begin
            pend_nxt = pend_r + CW'(1);
          end
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = {run_r, pop_r};
          ouser_nxt = (cur_r == '0);
          olast_nxt = !fin_r || ((cur_r == '0) && (pend_r == '0));
          if (cur_r == '0) begin
            cur_nxt  = pend_r;
            pend_nxt = cur_r;
            side_nxt = !side_r;
            if (run_r != RUN_MAX) begin
              run_nxt = run_r + RUN_W'(1);
            end
          end
          st_nxt = fin_r ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (cur_r == '0) begin
          if (pend_r != '0) begin
            // drain the pending heap as the next run
            cur_nxt  = pend_r;
            pend_nxt = cur_r;
            side_nxt = !side_r;
            if (run_r != RUN_MAX) begin
              run_nxt = run_r + RUN_W'(1);
            end
          end else begin
            // stream done: start over
            cur_nxt  = '0;
            pend_nxt = '0;
            fill_nxt = '0;
            run_nxt  = '0;
            side_nxt = 1'b0;
            st_nxt   = S_IDLE;
          end
        end else begin
          cmd_nxt  = '{start: 1'b1, op: OP_POP, half: side_r};
          ccnt_nxt = cur_r;
          st_nxt   = S_DPOPW;
        end
      end
      S_DPOPW: begin
        if (h_done) begin
          pop_nxt = h_data;
          cur_nxt = cur_r - CW'(1);
          st_nxt  = S_DEMIT;
        end
      end
      S_DEMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odata_nxt = {run_r, pop_r};
          ouser_nxt = (cur_r == '0);
          olast_nxt = (cur_r == '0) && (pend_r == '0);
          st_nxt    = S_DRAIN;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cur_r   <= '0;
      pend_r  <= '0;
      fill_r  <= '0;
      run_r   <= '0;
      side_r  <= 1'b0;
      cmd_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      fill_r  <= fill_nxt;
      run_r   <= run_nxt;
      side_r  <= side_nxt;
      cmd_r   <= cmd_nxt;
      ov_r    <= ov_nxt;
    end
    v_r     <= v_nxt;
    pop_r   <= pop_nxt;
    fin_r   <= fin_nxt;
    tocur_r <= tocur_nxt;
    ccnt_r  <= ccnt_nxt;
    cval_r  <= cval_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  rsrg_heap #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_r),
    .cmd_count (ccnt_r),
    .cmd_value (cval_r),
    .rsp_done  (h_done),
    .rsp_data  (h_data)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  // both heaps together never exceed the store
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_r} + {1'b0, pend_r}) <= (CW + 1)'(HEAP_DEPTH))
    else $error("heap counts exceed store depth");

  // engine completes only while the sequencer waits for it
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    h_done |-> (st_r == S_FILLW || st_r == S_POPW || st_r == S_PUSHW || st_r == S_DPOPW))
    else $error("heap response outside a wait state");

  // a finished stream leaves every counter cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DRAIN && cur_r == '0 && pend_r == '0) |=>
    (fill_r == '0 && run_r == '0 && !side_r && st_r == S_IDLE))
    else $error("stream end did not clear state");

  // a result is never placed over one still waiting
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready && (st_r == S_EMIT || st_r == S_DEMIT)) |=> $stable(st_r))
    else $error("result overwritten under stall");

endmodule

### tb/sv/replacement_selection_run_generator_top_test.sv
// Self-checking testbench for the replacement-selection run generator.
`timescale 1ns / 100ps

module replacement_selection_run_generator_top_test;
  import rsrg_pkg::*;

  localparam int DEPTH = HEAP_DEPTH_DEF;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
    logic             run_end;
    logic             fin;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [47:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [FILL_W-1:0] cfg_data;

  // predictor state
  logic [KEY_W-1:0] heap_mem [DEPTH];
  int               cur_cnt;
  int               pend_cnt;
  int               fill_cnt;
  int               run_cnt;
  bit               side;
  logic [FILL_W-1:0] fill_reg;

  result_t expected_q[$];
  int      errors;
  int      cycles;
  bit      quiet;
  int      stall_left;

  replacement_selection_run_generator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] value
    .in_tlast  (in_tlast),   // last_in
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [31:0] out_value, [47:32] run_number
    .out_tuser (out_tuser),  // run_end
    .out_tlast (out_tlast),  // last
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // heap_fill
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int addr(bit h, int i);
    if (i >= DEPTH) i = DEPTH - 1;
    return h ? DEPTH - 1 - i : i;
  endfunction

  function automatic bit key_less(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void swap_at(bit h, int a, int b);
    logic [KEY_W-1:0] t;
    t = heap_mem[addr(h, a)];
    heap_mem[addr(h, a)] = heap_mem[addr(h, b)];
    heap_mem[addr(h, b)] = t;
  endfunction

  function automatic void heap_insert(bit h, ref int cnt, input logic [KEY_W-1:0] v);
    int i;
    int p;
    i = cnt;
    if (i >= DEPTH) return;
    heap_mem[addr(h, i)] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!key_less(heap_mem[addr(h, i)], heap_mem[addr(h, p)])) break;
      swap_at(h, p, i);
      i = p;
    end
    cnt++;
  endfunction

  function automatic logic [KEY_W-1:0] heap_take_min(bit h, ref int cnt);
    int n;
    int i;
    int l;
    int r;
    int m;
    logic [KEY_W-1:0] top;
    if (cnt == 0) return '0;
    top = heap_mem[addr(h, 0)];
    n = cnt - 1;
    heap_mem[addr(h, 0)] = heap_mem[addr(h, n)];
    cnt = n;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < n && key_less(heap_mem[addr(h, l)], heap_mem[addr(h, m)])) m = l;
      if (r < n && key_less(heap_mem[addr(h, r)], heap_mem[addr(h, m)])) m = r;
      if (m == i) break;
      swap_at(h, i, m);
      i = m;
    end
    return top;
  endfunction

  function automatic void flip_heaps();
    int t;
    t = cur_cnt;
    cur_cnt = pend_cnt;
    pend_cnt = t;
    side = ~side;
    if (run_cnt < int'(RUN_MAX)) run_cnt++;
  endfunction

  function automatic void push_result(logic [KEY_W-1:0] k, bit e);
    result_t r;
    r.key = k;
    r.run = RUN_W'(run_cnt);
    r.run_end = e;
    r.fin = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void drain_runs();
    while (cur_cnt > 0) begin
      logic [KEY_W-1:0] k;
      k = heap_take_min(side, cur_cnt);
      push_result(k, cur_cnt == 0);
    end
  endfunction

  // Work out the results of one accepted request.
  function automatic void predict_runs(logic [KEY_W-1:0] v, bit fin);
    int eff;
    int base;
    logic [KEY_W-1:0] popped;
    base = expected_q.size();
    eff = fill_reg;
    if (eff < 1) eff = 1;
    if (eff > DEPTH) eff = DEPTH;
    if (fill_cnt < eff) begin
      heap_insert(side, cur_cnt, v);
      fill_cnt++;
    end else begin
      if (cur_cnt == 0) flip_heaps();
      popped = heap_take_min(side, cur_cnt);
      if (key_less(popped, v)) heap_insert(side, cur_cnt, v);
      else heap_insert(~side, pend_cnt, v);
      push_result(popped, cur_cnt == 0);
      if (cur_cnt == 0) flip_heaps();
    end
    if (fin) begin
      drain_runs();
      if (pend_cnt > 0) begin
        flip_heaps();
        drain_runs();
      end
      cur_cnt = 0;
      pend_cnt = 0;
      fill_cnt = 0;
      run_cnt = 0;
      side = 1'b0;
    end
    if (expected_q.size() > base) expected_q[$].fin = 1'b1;
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result got %h/%h/%b/%b", $time, out_tdata[31:0],
                 out_tdata[47:32], out_tuser, out_tlast);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.key) begin
          $display("%0t: key exp %h act %h", $time, want.key, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[47:32] !== want.run) begin
          $display("%0t: run exp %0d act %0d", $time, want.run, out_tdata[47:32]);
          errors++;
        end
        if (out_tuser !== want.run_end) begin
          $display("%0t: run_end exp %b act %b", $time, want.run_end, out_tuser);
          errors++;
        end
        if (out_tlast !== want.fin) begin
          $display("%0t: last exp %b act %b", $time, want.fin, out_tlast);
          errors++;
        end
      end
    end
  end

  // Stall the receiver in random bursts.
  always @(posedge clk) begin
    if (quiet) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[replacement_selection_run_generator_top] ERROR");
      $finish;
    end
  end

  // Send one request and predict its results.
  task automatic send_key(logic [KEY_W-1:0] v, bit fin);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_runs(v, fin);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40 * DEPTH) @(posedge clk);
  endtask

  task automatic write_fill(logic [FILL_W-1:0] f);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_reg = f;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return KEY_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Extremes, fill-phase ending, out-of-range fill values.
  task automatic test_directed();
    write_fill(6'd3);
    send_key(32'h7fff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hffff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h5555_aaaa, 1'b1);
    send_key(32'haaaa_5555, 1'b0);
    send_key(32'h0000_0001, 1'b1);
    write_fill(6'd0);
    send_key(32'h0000_0009, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    send_key(32'h0000_0002, 1'b0);
    send_key(32'h0000_0007, 1'b1);
    write_fill(6'd63);
    for (int i = 0; i < 8; i++) send_key(KEY_W'(i * 3 - 9), i == 7);
  endtask

  // Well-formed streams of random length under one fill setting.
  task automatic test_streams(logic [FILL_W-1:0] f, int items, bit pause);
    int left;
    int len;
    write_fill(f);
    left = items;
    while (left > 0) begin
      len = $urandom_range(1, 3 * (f == 0 ? 1 : f) + 10);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        send_key(rand_key(), i == len - 1);
        if (pause && i == len / 2)
          while (expected_q.size() != 0) @(posedge clk);
      end
      left -= len;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_tready = 1'b0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    cur_cnt = 0;
    pend_cnt = 0;
    fill_cnt = 0;
    run_cnt = 0;
    side = 1'b0;
    fill_reg = HEAP_FILL_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streams(6'd1, 80, 1'b1);
    test_streams(6'd32, 120, 1'b0);
    test_streams(6'd4, 120, 1'b0);
    test_streams(6'd13, 100, 1'b0);
    quiet = 1'b1;
    test_streams(6'd2, 80, 1'b0);
    wait_idle();
    if (errors == 0) $display("[replacement_selection_run_generator_top] OK");
    else $display("[replacement_selection_run_generator_top] ERROR");
    $finish;
  end

endmodule
